// File: hw/rtl/gtc_pkg.sv
// Package for the gated timer/counter bank.
// Holds the request command codes, mode register bit positions and sizing constants.
// Depends on nothing; every other file of the block imports it.
package gtc_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int LINE_RATE = 9371;
  localparam int OUT_BITS = (NUM_TIMERS < 4) ? NUM_TIMERS : 4;

  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_WRITE_COUNT  = 3'd1,
    CMD_WRITE_MODE   = 3'd2,
    CMD_WRITE_TARGET = 3'd3,
    CMD_READ_COUNT   = 3'd4,
    CMD_GATE_START   = 3'd5,
    CMD_GATE_END     = 3'd6,
    CMD_NOP          = 3'd7
  } command_t;

  typedef logic [11:0] mode_t;
  typedef logic [15:0] count_t;

  localparam int M_GATE_EN  = 2;
  localparam int M_GATE_SRC = 3;
  localparam int M_RST_TGT  = 6;
  localparam int M_ENABLE   = 7;
  localparam int M_IRQ_TGT  = 8;
  localparam int M_IRQ_OVF  = 9;
  localparam int M_FLAG_TGT = 10;
  localparam int M_FLAG_OVF = 11;

  localparam logic [9:0] M_LOW_MASK = 10'h3ff;
  localparam logic [3:0] M_GATE_OFF_CODE = 4'h7;

  localparam logic [1:0] CLK_DIV2 = 2'd0;
  localparam logic [1:0] CLK_DIV32 = 2'd1;
  localparam logic [1:0] CLK_DIV512 = 2'd2;
  localparam logic [1:0] CLK_LINE = 2'd3;

  localparam logic [1:0] GATE_FREEZE = 2'd0;
  localparam logic [1:0] GATE_RESTART_START = 2'd1;
  localparam logic [1:0] GATE_RESTART_END = 2'd2;
  localparam logic [1:0] GATE_RESTART_BOTH = 2'd3;

  localparam count_t COUNT_MAX = 16'hffff;

endpackage

// File: hw/rtl/gtc_channels.sv
// Valid/ready channel interfaces for the gated timer/counter bank.
// One carries requests into the bank, the other carries results out.
// Depends on gtc_pkg for the command type.
interface gtc_request_if
  import gtc_pkg::*;
();
  logic       valid;
  logic       ready;
  command_t   command;
  logic [1:0] counter_index;
  logic [15:0] write_data;
  logic       gate_source;

  modport source (output valid, command, counter_index, write_data, gate_source,
                  input ready);
  modport sink (input valid, command, counter_index, write_data, gate_source,
                output ready);
endinterface

interface gtc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic [3:0]  irq_lines;
  logic [3:0]  target_flags;
  logic [3:0]  overflow_flags;

  modport source (output valid, read_data, irq_lines, target_flags, overflow_flags,
                  input ready);
  modport sink (input valid, read_data, irq_lines, target_flags, overflow_flags,
                output ready);
endinterface

// File: hw/rtl/gated_timer_counter_bank.sv
// Top level of the gated timer/counter bank: four 16-bit timers with prescalers and gating.
// Depends on gtc_pkg and on the channel interfaces in gtc_channels.sv.
//
// Usage: each request on the request channel is a clock tick, a count, mode or target
// write, a count read, or a gate start/end event. Every accepted request yields exactly
// one result on the result channel: the read count (zero unless a read), the timers that
// raised an interrupt on this request, and the target and overflow flags afterwards.
// All state is updated in the cycle a request is accepted, by a single pass of logic,
// and the result is captured in the output register.
// Throughput is one request per cycle while the receiver keeps up; a tick must be sent for every bus clock.
// The request channel is ready whenever the output register is empty or is being
// emptied in the same cycle, so a stalled receiver stalls the sender after one
// pending result and nothing is lost or repeated.
// Reset clears all counts, modes, gate states and prescaler phases, sets every target
// to 0xffff and empties the output register.
module gated_timer_counter_bank
  import gtc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  gtc_request_if.sink  request,
  gtc_result_if.source result
);

  count_t       timer_count [NUM_TIMERS];
  mode_t        timer_mode [NUM_TIMERS];
  count_t       timer_target [NUM_TIMERS];
  logic         gate_active [NUM_TIMERS];
  logic [8:0]   cycle_phase;
  logic [15:0]  line_phase;

  count_t       timer_count_next [NUM_TIMERS];
  mode_t        timer_mode_next [NUM_TIMERS];
  count_t       timer_target_next [NUM_TIMERS];
  logic         gate_active_next [NUM_TIMERS];
  logic [8:0]   cycle_phase_next;
  logic [15:0]  line_phase_next;

  logic         accept;
  logic [15:0]  rd_value;
  logic [NUM_TIMERS-1:0] irq_value;
  logic [3:0]   irq_out_value;
  logic [3:0]   tf_value;
  logic [3:0]   of_value;

  logic         out_valid;
  logic [15:0]  out_read_data;
  logic [3:0]   out_irq;
  logic [3:0]   out_tf;
  logic [3:0]   out_of;

  assign request.ready = !out_valid || result.ready;
  assign accept = request.valid && request.ready;

  always_comb begin
    logic [16:0] line_sum;
    logic        fline;
    logic        f2;
    logic        f32;
    logic        f512;
    logic        fire;
    logic [16:0] inc;
    mode_t       m;
    logic        is_start;
    logic [1:0]  gm;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_count_next[i] = timer_count[i];
      timer_mode_next[i] = timer_mode[i];
      timer_target_next[i] = timer_target[i];
      gate_active_next[i] = gate_active[i];
    end
    cycle_phase_next = cycle_phase;
    line_phase_next = line_phase;
    rd_value = '0;
    irq_value = '0;
    line_sum = {1'b0, line_phase} + 17'd1;
    fline = line_sum >= 17'(LINE_RATE);
    f2 = 1'b0;
    f32 = 1'b0;
    f512 = 1'b0;
    fire = 1'b0;
    inc = '0;
    m = '0;
    is_start = request.command == CMD_GATE_START;
    gm = '0;

    if (accept) begin
      case (request.command)
        CMD_TICK: begin
          cycle_phase_next = cycle_phase + 9'd1;
          line_phase_next = fline ? 16'd0 : line_sum[15:0];
          f2 = !cycle_phase_next[0];
          f32 = cycle_phase_next[4:0] == 5'd0;
          f512 = cycle_phase_next == 9'd0;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            case (timer_mode[i][1:0])
              CLK_DIV2:   fire = f2;
              CLK_DIV32:  fire = f32;
              CLK_DIV512: fire = f512;
              default:    fire = fline;
            endcase
            if (timer_mode[i][M_ENABLE] && fire) begin
              inc = {1'b0, timer_count[i]} + 17'd1;
              m = timer_mode[i];
              if (inc == {1'b0, timer_target[i]}) begin
                m[M_FLAG_TGT] = 1'b1;
                if (m[M_IRQ_TGT]) irq_value[i] = 1'b1;
                if (m[M_RST_TGT]) inc = '0;
              end
              if (inc >= {1'b0, COUNT_MAX}) begin
                m[M_FLAG_OVF] = 1'b1;
                if (m[M_IRQ_OVF]) irq_value[i] = 1'b1;
                inc = '0;
              end
              timer_mode_next[i] = m;
              timer_count_next[i] = inc[15:0];
            end
          end
        end
        CMD_WRITE_COUNT: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(request.counter_index) == i) timer_count_next[i] = request.write_data;
          end
        end
        CMD_WRITE_MODE: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(request.counter_index) == i) begin
              m = '0;
              m[M_FLAG_TGT] = timer_mode[i][M_FLAG_TGT] && !request.write_data[M_FLAG_TGT];
              m[M_FLAG_OVF] = timer_mode[i][M_FLAG_OVF] && !request.write_data[M_FLAG_OVF];
              m[9:0] = request.write_data[9:0] & M_LOW_MASK;
              if (m[3:0] == M_GATE_OFF_CODE) begin
                gate_active_next[i] = 1'b0;
                m[M_ENABLE] = 1'b0;
              end else if (m[M_GATE_EN]) begin
                gate_active_next[i] = 1'b1;
                m[M_ENABLE] = 1'b0;
                m[M_FLAG_TGT] = 1'b0;
                m[M_FLAG_OVF] = 1'b0;
                timer_count_next[i] = '0;
              end else begin
                gate_active_next[i] = 1'b0;
              end
              timer_mode_next[i] = m;
            end
          end
        end
        CMD_WRITE_TARGET: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(request.counter_index) == i) timer_target_next[i] = request.write_data;
          end
        end
        CMD_READ_COUNT: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (32'(request.counter_index) == i) rd_value = timer_count[i];
          end
        end
        CMD_GATE_START, CMD_GATE_END: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            gm = timer_mode[i][5:4];
            if (gate_active[i] && (timer_mode[i][M_GATE_SRC] == request.gate_source)) begin
              if (gm == GATE_FREEZE) begin
                timer_mode_next[i][M_ENABLE] = !is_start;
              end else if (gm == GATE_RESTART_BOTH || (gm == GATE_RESTART_START && is_start)
                           || (gm == GATE_RESTART_END && !is_start)) begin
                timer_mode_next[i][M_ENABLE] = 1'b1;
                timer_mode_next[i][M_FLAG_TGT] = 1'b0;
                timer_mode_next[i][M_FLAG_OVF] = 1'b0;
                timer_count_next[i] = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    irq_out_value = '0;
    tf_value = '0;
    of_value = '0;
    for (int i = 0; i < OUT_BITS; i++) begin
      irq_out_value[i] = irq_value[i];
      tf_value[i] = timer_mode_next[i][M_FLAG_TGT];
      of_value[i] = timer_mode_next[i][M_FLAG_OVF];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_count[i] <= '0;
        timer_mode[i] <= '0;
        timer_target[i] <= COUNT_MAX;
        gate_active[i] <= 1'b0;
      end
      cycle_phase <= '0;
      line_phase <= '0;
      out_valid <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        timer_count[i] <= timer_count_next[i];
        timer_mode[i] <= timer_mode_next[i];
        timer_target[i] <= timer_target_next[i];
        gate_active[i] <= gate_active_next[i];
      end
      cycle_phase <= cycle_phase_next;
      line_phase <= line_phase_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_data <= rd_value;
      out_irq <= irq_out_value;
      out_tf <= tf_value;
      out_of <= of_value;
    end
  end

  assign result.valid = out_valid;
  assign result.read_data = out_read_data;
  assign result.irq_lines = out_irq;
  assign result.target_flags = out_tf;
  assign result.overflow_flags = out_of;

endmodule

// File: test/tb_top.sv
// Testbench for the gated timer/counter bank: directed and random requests, checked against
// a cycle-free model of the four timers that predicts every result of the bank.
// Depends on gtc_pkg, the channel interfaces in gtc_channels.sv and gated_timer_counter_bank.
module tb_top;
  import gtc_pkg::*;

  typedef struct packed {
    command_t    command;
    logic [1:0]  counter_index;
    logic [15:0] write_data;
    logic        gate_source;
  } timer_request_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [3:0]  irq_lines;
    logic [3:0]  target_flags;
    logic [3:0]  overflow_flags;
  } timer_result_t;

  localparam mode_t BIT_GATE_EN = mode_t'(1 << M_GATE_EN);
  localparam mode_t BIT_RST_TGT = mode_t'(1 << M_RST_TGT);
  localparam mode_t BIT_ENABLE = mode_t'(1 << M_ENABLE);
  localparam mode_t BIT_IRQ_TGT = mode_t'(1 << M_IRQ_TGT);
  localparam mode_t BIT_IRQ_OVF = mode_t'(1 << M_IRQ_OVF);
  localparam mode_t FLAG_MASK = mode_t'((1 << M_FLAG_TGT) | (1 << M_FLAG_OVF));
  localparam int TIMEOUT_CYCLES = 600000;

  logic clk;
  logic rst;

  gtc_request_if request();
  gtc_result_if result();

  gated_timer_counter_bank DUT (
    .clk(clk),
    .rst(rst),
    .request(request),
    .result(result)
  );

  count_t bank_count [NUM_TIMERS] = '{default: '0};
  mode_t bank_mode [NUM_TIMERS] = '{default: '0};
  count_t bank_target [NUM_TIMERS] = '{default: COUNT_MAX};
  logic bank_gated [NUM_TIMERS] = '{default: 1'b0};
  logic [8:0] cycle_phase = '0;
  logic [15:0] line_phase = '0;

  timer_request_t pending_requests[$];
  timer_result_t expected_results[$];
  logic request_taken = 1'b0;
  int error_count = 0;
  int cycle_count = 0;
  int rx_cycle = 0;

  // One prescaled increment of timer i; returns the interrupt it raises.
  function automatic logic timer_increment(int i);
    logic [16:0] next_count;
    logic irq;
    irq = 1'b0;
    next_count = {1'b0, bank_count[i]} + 17'd1;
    if (next_count == {1'b0, bank_target[i]}) begin
      bank_mode[i][M_FLAG_TGT] = 1'b1;
      if (bank_mode[i][M_IRQ_TGT]) irq = 1'b1;
      if (bank_mode[i][M_RST_TGT]) next_count = '0;
    end
    if (next_count >= {1'b0, COUNT_MAX}) begin
      bank_mode[i][M_FLAG_OVF] = 1'b1;
      if (bank_mode[i][M_IRQ_OVF]) irq = 1'b1;
      next_count = '0;
    end
    bank_count[i] = next_count[15:0];
    return irq;
  endfunction

  function automatic void restart_timer(int i);
    bank_count[i] = '0;
    bank_mode[i] = bank_mode[i] & ~FLAG_MASK;
  endfunction

  function automatic void apply_gate_edge(logic src, logic is_start);
    logic [1:0] gate_mode;
    int i;
    for (i = 0; i < NUM_TIMERS; i++) begin
      if (bank_gated[i] && bank_mode[i][M_GATE_SRC] == src) begin
        gate_mode = bank_mode[i][5:4];
        if (gate_mode == GATE_FREEZE) begin
          bank_mode[i][M_ENABLE] = !is_start;
        end else if (gate_mode == GATE_RESTART_BOTH ||
                     (gate_mode == GATE_RESTART_START && is_start) ||
                     (gate_mode == GATE_RESTART_END && !is_start)) begin
          bank_mode[i][M_ENABLE] = 1'b1;
          restart_timer(i);
        end
      end
    end
  endfunction

  function automatic timer_result_t timer_bank_step(timer_request_t req);
    timer_result_t res;
    logic fire_line;
    logic fire;
    logic in_range;
    mode_t new_mode;
    int idx;
    int i;
    res = '0;
    idx = int'(req.counter_index);
    in_range = idx < NUM_TIMERS;
    case (req.command)
      CMD_TICK: begin
        cycle_phase = cycle_phase + 9'd1;
        fire_line = 1'b0;
        if (int'(line_phase) + 1 >= LINE_RATE) begin
          line_phase = '0;
          fire_line = 1'b1;
        end else begin
          line_phase = line_phase + 16'd1;
        end
        for (i = 0; i < NUM_TIMERS; i++) begin
          case (bank_mode[i][1:0])
            CLK_DIV2: fire = cycle_phase[0] == 1'b0;
            CLK_DIV32: fire = cycle_phase[4:0] == 5'd0;
            CLK_DIV512: fire = cycle_phase == 9'd0;
            default: fire = fire_line;
          endcase
          if (bank_mode[i][M_ENABLE] && fire) begin
            if (timer_increment(i) && i < OUT_BITS) res.irq_lines[i] = 1'b1;
          end
        end
      end
      CMD_WRITE_COUNT: begin
        if (in_range) bank_count[idx] = req.write_data;
      end
      CMD_WRITE_MODE: begin
        if (in_range) begin
          new_mode = bank_mode[idx] & FLAG_MASK & ~(req.write_data[11:0] & FLAG_MASK);
          new_mode[9:0] = req.write_data[9:0];
          if (new_mode[3:0] == M_GATE_OFF_CODE) begin
            bank_gated[idx] = 1'b0;
            new_mode[M_ENABLE] = 1'b0;
            bank_mode[idx] = new_mode;
          end else if (new_mode[M_GATE_EN]) begin
            bank_gated[idx] = 1'b1;
            new_mode[M_ENABLE] = 1'b0;
            bank_mode[idx] = new_mode;
            restart_timer(idx);
          end else begin
            bank_gated[idx] = 1'b0;
            bank_mode[idx] = new_mode;
          end
        end
      end
      CMD_WRITE_TARGET: begin
        if (in_range) bank_target[idx] = req.write_data;
      end
      CMD_READ_COUNT: begin
        if (in_range) res.read_data = bank_count[idx];
      end
      CMD_GATE_START: apply_gate_edge(req.gate_source, 1'b1);
      CMD_GATE_END: apply_gate_edge(req.gate_source, 1'b0);
      default: ;
    endcase
    for (i = 0; i < OUT_BITS; i++) begin
      res.target_flags[i] = bank_mode[i][M_FLAG_TGT];
      res.overflow_flags[i] = bank_mode[i][M_FLAG_OVF];
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endfunction

  task automatic queue_request(command_t cmd, int idx, int data, int src);
    timer_request_t req;
    req.command = cmd;
    req.counter_index = idx[1:0];
    req.write_data = data[15:0];
    req.gate_source = src[0];
    pending_requests.push_back(req);
  endtask

  // Program one timer, often near its target or near overflow, then let it run among other requests.
  task automatic queue_timer_scenario();
    int t;
    int span;
    int pick;
    mode_t mode_bits;
    count_t tgt;
    count_t start;
    t = $urandom_range(0, NUM_TIMERS - 1);
    case ($urandom_range(0, 3))
      0: tgt = count_t'($urandom_range(1, 40));
      1: tgt = COUNT_MAX;
      default: tgt = count_t'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: start = count_t'(COUNT_MAX - $urandom_range(0, 12));
      1: start = count_t'($urandom_range(0, 8));
      2: start = tgt - count_t'($urandom_range(0, 12));
      default: start = count_t'($urandom);
    endcase
    mode_bits = mode_t'($urandom);
    pick = $urandom_range(0, 99);
    mode_bits[1:0] = pick < 70 ? CLK_DIV2 : pick < 90 ? CLK_DIV32 : pick < 97 ? CLK_DIV512 : CLK_LINE;
    mode_bits[M_ENABLE] = $urandom_range(0, 99) < 85;
    mode_bits[M_GATE_EN] = $urandom_range(0, 99) < 30;
    queue_request(CMD_WRITE_TARGET, t, int'(tgt), $urandom_range(0, 1));
    if ($urandom_range(0, 1)) begin
      queue_request(CMD_WRITE_COUNT, t, int'(start), $urandom_range(0, 1));
      queue_request(CMD_WRITE_MODE, t, int'(mode_bits), $urandom_range(0, 1));
    end else begin
      queue_request(CMD_WRITE_MODE, t, int'(mode_bits), $urandom_range(0, 1));
      queue_request(CMD_WRITE_COUNT, t, int'(start), $urandom_range(0, 1));
    end
    span = $urandom_range(4, 48);
    repeat (span) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        queue_request(CMD_TICK, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
      end else if (pick < 83) begin
        queue_request(CMD_READ_COUNT, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
      end else if (pick < 88) begin
        queue_request(CMD_GATE_START, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
      end else if (pick < 93) begin
        queue_request(CMD_GATE_END, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
      end else if (pick < 96) begin
        queue_request(CMD_WRITE_COUNT, $urandom_range(0, 3), $urandom, $urandom_range(0, 1));
      end else begin
        queue_request(command_t'($urandom_range(0, 7)), $urandom_range(0, 3), $urandom,
                      $urandom_range(0, 1));
      end
    end
  endtask

  task automatic queue_random_scenario();
    if ($urandom_range(0, 99) < 80) begin
      queue_timer_scenario();
    end else begin
      repeat ($urandom_range(1, 5)) begin
        queue_request(command_t'($urandom_range(0, 7)), $urandom_range(0, 3), $urandom,
                      $urandom_range(0, 1));
      end
    end
  endtask

  // The divide-by-512 prescaler only fires over a long tick run.
  task automatic queue_long_tick_run();
    queue_request(CMD_WRITE_TARGET, 0, int'(COUNT_MAX), 0);
    queue_request(CMD_WRITE_COUNT, 0, 'hfffe, 0);
    queue_request(CMD_WRITE_MODE, 0,
                  int'(FLAG_MASK | BIT_ENABLE | BIT_IRQ_TGT | BIT_IRQ_OVF | CLK_LINE), 0);
    queue_request(CMD_WRITE_TARGET, 1, 'hfff8, 0);
    queue_request(CMD_WRITE_COUNT, 1, 'hfff0, 0);
    queue_request(CMD_WRITE_MODE, 1, int'(BIT_ENABLE | BIT_IRQ_TGT | BIT_RST_TGT | CLK_DIV512), 0);
    repeat (520) queue_request(CMD_TICK, 0, 0, 0);
    queue_request(CMD_READ_COUNT, 0, 0, 0);
    queue_request(CMD_READ_COUNT, 1, 0, 0);
  endtask

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : reset_gen
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : stimulus
    int goal;
    queue_request(CMD_READ_COUNT, 0, 0, 0);
    queue_request(CMD_WRITE_TARGET, 0, 3, 0);
    queue_request(CMD_WRITE_MODE, 0, int'(BIT_ENABLE | BIT_IRQ_TGT | BIT_RST_TGT | CLK_DIV2), 0);
    repeat (6) queue_request(CMD_TICK, 0, 0, 0);
    // Target and overflow together: count reaches 0xffff while the target is 0xffff.
    queue_request(CMD_WRITE_COUNT, 1, 'hfffe, 0);
    queue_request(CMD_WRITE_MODE, 1, int'(BIT_ENABLE | BIT_IRQ_OVF | CLK_DIV2), 0);
    repeat (2) queue_request(CMD_TICK, 0, 0, 0);
    // A count already at 0xffff wraps on its next increment.
    queue_request(CMD_WRITE_COUNT, 3, 'hffff, 1);
    queue_request(CMD_WRITE_MODE, 3, int'(BIT_ENABLE | BIT_IRQ_OVF | BIT_IRQ_TGT | CLK_DIV2), 1);
    repeat (2) queue_request(CMD_TICK, 3, 'hffff, 1);
    queue_request(CMD_READ_COUNT, 1, 0, 0);
    queue_request(CMD_WRITE_MODE, 1, 'hffff, 1);
    queue_request(CMD_GATE_START, 0, 0, 1);
    queue_request(CMD_WRITE_MODE, 2, int'(BIT_GATE_EN | BIT_ENABLE | CLK_DIV2), 0);
    queue_request(CMD_GATE_END, 0, 0, 0);
    queue_request(CMD_GATE_START, 0, 0, 0);
    queue_request(CMD_WRITE_MODE, 3, int'(mode_t'(M_GATE_OFF_CODE) | BIT_ENABLE), 0);
    queue_request(CMD_NOP, 3, 'hffff, 1);

    while (pending_requests.size() < 150) queue_random_scenario();
    queue_long_tick_run();
    goal = pending_requests.size() + 150;
    while (pending_requests.size() < goal) queue_random_scenario();

    wait (rst === 1'b0);
    while (pending_requests.size() > 0 || request.valid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(negedge clk) begin : driver
    timer_request_t next_req;
    int burst_left;
    int gap_left;
    if (rst) begin
      request.valid <= 1'b0;
      request.command <= CMD_NOP;
      request.counter_index <= '0;
      request.write_data <= '0;
      request.gate_source <= 1'b0;
    end else if (!request.valid || request_taken) begin
      if (gap_left > 0 || pending_requests.size() == 0) begin
        if (gap_left > 0) gap_left = gap_left - 1;
        request.valid <= 1'b0;
      end else begin
        next_req = pending_requests.pop_front();
        request.valid <= 1'b1;
        request.command <= next_req.command;
        request.counter_index <= next_req.counter_index;
        request.write_data <= next_req.write_data;
        request.gate_source <= next_req.gate_source;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    rx_cycle = rx_cycle + 1;
    case ((rx_cycle / 300) % 3)
      0: result.ready <= 1'b1;
      1: result.ready <= $urandom_range(0, 99) >= 35;
      default: result.ready <= (rx_cycle % 9) < 5;
    endcase
  end

  always @(posedge clk) begin : monitor
    timer_result_t want;
    if (rst) begin
      request_taken <= 1'b0;
    end else begin
      request_taken <= request.valid && request.ready;
      if (result.valid && result.ready) begin
        if (expected_results.size() == 0) begin
          $error("result arrived with no request outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.read_data, result.read_data);
          check_field("irq_lines", 16'(want.irq_lines), 16'(result.irq_lines));
          check_field("target_flags", 16'(want.target_flags), 16'(result.target_flags));
          check_field("overflow_flags", 16'(want.overflow_flags), 16'(result.overflow_flags));
        end
      end
      if (request.valid && request.ready) begin
        expected_results.push_back(timer_bank_step('{
          command: request.command,
          counter_index: request.counter_index,
          write_data: request.write_data,
          gate_source: request.gate_source
        }));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count = cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
